// ===== src/mpls_pkg.sv =====
package mpls_pkg;

  // Motor count and field and register widths
  localparam int NUM_MOTORS = 4;
  localparam int COEF_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CUR_W      = 16;
  localparam int LIM_W      = 20;
  localparam int ETA_W      = 16;

  // eta = 1.0 in Q1.15
  localparam logic [ETA_W-1:0] ETA_ONE = 16'h8000;

  // Cycles from an accepted start to the edge that takes its result
  localparam int LATENCY = 65;

  // Coefficient register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONST      = 3'd0,
    REG_CURRENT    = 3'd1,
    REG_SPEED      = 3'd2,
    REG_CROSS      = 3'd3,
    REG_CURRENT_SQ = 3'd4,
    REG_SPEED_SQ   = 3'd5
  } cfg_reg_e;

  // Outcome of one root lane
  typedef enum logic [1:0] {
    LANE_ZERO = 2'd0,
    LANE_ONE  = 2'd1,
    LANE_DIV  = 2'd2
  } lane_mode_e;

  typedef struct packed {
    logic signed [CUR_W-1:0] current_0;
    logic signed [CUR_W-1:0] current_1;
    logic signed [CUR_W-1:0] current_2;
    logic signed [CUR_W-1:0] current_3;
    logic signed [CUR_W-1:0] speed_0;
    logic signed [CUR_W-1:0] speed_1;
    logic signed [CUR_W-1:0] speed_2;
    logic signed [CUR_W-1:0] speed_3;
    logic        [LIM_W-1:0] power_limit;
  } in_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] out_current_0;
    logic signed [CUR_W-1:0] out_current_1;
    logic signed [CUR_W-1:0] out_current_2;
    logic signed [CUR_W-1:0] out_current_3;
    logic        [ETA_W-1:0] scale_factor;
    logic                    was_limited;
  } out_t;

endpackage

// ===== src/motor_power_limit_scaler.sv =====
// Channel  | Direction | Signals                          | Beat taken when
// ---------+-----------+----------------------------------+-------------------------------
// command  | in, out   | start, busy, in_i                | start high, busy low
// result   | out       | result_valid_o, result_o         | every cycle result_valid_o high
// config   | in, out   | cfg_valid_i, cfg_ready_o,        | cfg_valid_i and cfg_ready_o
//          |           | cfg_index_i, cfg_data_i          |
//
// A command may be issued every cycle; its result shows for one cycle.
// Most of the latency lies in the 32-step square root pipe and the two 16-step eta divider pipes.
// rst_ni clears the coefficients (to zero) and all stage valid bits; nothing waits after it.
// The result side cannot stall, so the pipe always advances and busy stays low.
module motor_power_limit_scaler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  mpls_pkg::in_t                       in_i,
  output logic                                result_valid_o,
  output mpls_pkg::out_t                      result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mpls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mpls_pkg::COEF_W-1:0]         cfg_data_i
);
  import mpls_pkg::*;

  localparam int NK    = 5;   // product terms per motor
  localparam int SQ_N  = 32;  // square root steps
  localparam int DV_N  = 16;  // eta divider steps
  localparam int SW    = 52;  // power sum width
  localparam int RW    = 54;  // divider remainder width

  localparam logic signed [45:0] K1000 = 46'sd1000;
  localparam logic signed [45:0] K1001 = 46'sd1001;

  typedef struct packed {
    logic                         limited;
    logic                         a_zero;
    logic                         d_neg;
    logic                         lin_ok;
    logic signed [30:0]           a2;
    logic signed [30:0]           b2;
    logic [SW-1:0]                mag_b;
    logic [SW-1:0]                mag_c;
    logic [NUM_MOTORS-1:0][CUR_W-1:0] cur;
  } side_t;

  function automatic logic [SW-1:0] mag_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] n;
    n = -v;
    return v[SW-1] ? n : v;
  endfunction

  logic accept;
  assign accept      = start & ~busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Coefficient registers
  logic signed [COEF_W-1:0] coef_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) coef_q[k] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CONST:      coef_q[0] <= cfg_data_i;
        REG_CURRENT:    coef_q[1] <= cfg_data_i;
        REG_SPEED:      coef_q[2] <= cfg_data_i;
        REG_CROSS:      coef_q[3] <= cfg_data_i;
        REG_CURRENT_SQ: coef_q[4] <= cfg_data_i;
        REG_SPEED_SQ:   coef_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits, one per register stage
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // ---------------- stage declarations ----------------
  logic signed [CUR_W-1:0] s1_cur_q [NUM_MOTORS];
  logic signed [CUR_W-1:0] s1_spd_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s1_lim_q;

  logic signed [31:0]      s2_x_d [NUM_MOTORS][NK];
  logic signed [31:0]      s2_x_q [NUM_MOTORS][NK];
  logic signed [CUR_W-1:0] s2_cur_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s2_lim_q;

  logic signed [55:0]      s3_ph_d [NUM_MOTORS][NK];
  logic signed [56:0]      s3_pl_d [NUM_MOTORS][NK];
  logic signed [55:0]      s3_ph_q [NUM_MOTORS][NK];
  logic signed [56:0]      s3_pl_q [NUM_MOTORS][NK];
  logic signed [CUR_W-1:0] s3_cur_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s3_lim_q;

  logic signed [80:0]      s4_full [NUM_MOTORS][NK];
  logic signed [47:0]      s4_t_q [NUM_MOTORS][NK];
  logic signed [CUR_W-1:0] s4_cur_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s4_lim_q;

  logic signed [48:0]      s5_a_q [NUM_MOTORS];
  logic signed [48:0]      s5_b_q [NUM_MOTORS];
  logic signed [48:0]      s5_c_q [NUM_MOTORS];
  logic signed [CUR_W-1:0] s5_cur_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s5_lim_q;

  logic signed [SW-1:0]    s6_a_d, s6_b_d, s6_c_d;
  logic signed [SW-1:0]    s6_a_q, s6_b_q, s6_c_q;
  logic signed [CUR_W-1:0] s6_cur_q [NUM_MOTORS];
  logic [LIM_W-1:0]        s6_lim_q;

  logic signed [SW-1:0]    s7_total, s7_lim;
  logic signed [SW-1:0]    s7_a_q, s7_b_q, s7_c_q;
  logic                    s7_limited_q;
  logic signed [CUR_W-1:0] s7_cur_q [NUM_MOTORS];

  logic [SW-1:0]           s8_mag_q [3];
  logic [2:0]              s8_sgn_q;
  logic                    s8_limited_q;
  logic signed [CUR_W-1:0] s8_cur_q [NUM_MOTORS];

  logic [SW-1:0]           s9_or;
  logic [4:0]              s9_sh_d, s9_sh_q;
  logic [SW-1:0]           s9_mag_q [3];
  logic [2:0]              s9_sgn_q;
  logic                    s9_limited_q;
  logic signed [CUR_W-1:0] s9_cur_q [NUM_MOTORS];

  logic [SW-1:0]           s10_shr [3];
  logic signed [30:0]      s10_v [3];
  logic signed [30:0]      s10_c2_q;
  side_t                   s10_side_d, s10_side_q;

  logic signed [61:0]      s11_bb_q, s11_ac_q;
  side_t                   s11_side_q;

  logic signed [63:0]      s12_delta;
  logic [62:0]             sq_v_d [SQ_N+1];
  logic [62:0]             sq_r_d [SQ_N+1];
  side_t                   sq_side_d [SQ_N+1];
  logic [62:0]             sq_v_q [SQ_N+1];
  logic [62:0]             sq_r_q [SQ_N+1];
  side_t                   sq_side_q [SQ_N+1];
  logic [63:0]             sq_sum [SQ_N];
  logic [62:0]             sq_bit [SQ_N];

  logic signed [33:0]      r1_sq, r1_nb;
  logic signed [33:0]      r1_n_d [2];
  logic signed [32:0]      r1_d_d;
  logic signed [33:0]      r1_n_q [2];
  logic signed [32:0]      r1_d_q;
  side_t                   r1_side_q;

  logic                    r2_inv [2];
  logic                    r2_one [2];
  lane_mode_e              r2_root_mode [2];

  logic [RW-1:0]           dv_rem_d [DV_N+1][2];
  logic [RW-1:0]           dv_den_d [DV_N+1][2];
  logic [ETA_W-1:0]        dv_quo_d [DV_N+1][2];
  lane_mode_e              dv_mode_d [DV_N+1][2];
  logic                    dv_lim_d [DV_N+1];
  logic [NUM_MOTORS-1:0][CUR_W-1:0] dv_cur_d [DV_N+1];
  logic [RW-1:0]           dv_rem_q [DV_N+1][2];
  logic [RW-1:0]           dv_den_q [DV_N+1][2];
  logic [ETA_W-1:0]        dv_quo_q [DV_N+1][2];
  lane_mode_e              dv_mode_q [DV_N+1][2];
  logic                    dv_lim_q [DV_N+1];
  logic [NUM_MOTORS-1:0][CUR_W-1:0] dv_cur_q [DV_N+1];
  logic [RW-1:0]           dv_rr [DV_N][2];

  logic [ETA_W-1:0]        e_lane [2];
  logic [ETA_W-1:0]        e_eta_d, e_eta_q;
  logic                    e_lim_q;
  logic [NUM_MOTORS-1:0][CUR_W-1:0] e_cur_q;

  logic signed [32:0]      m_p_q [NUM_MOTORS];
  logic [ETA_W-1:0]        m_eta_q;
  logic                    m_lim_q;

  logic [32:0]             o_mag [NUM_MOTORS];
  logic [17:0]             o_shr [NUM_MOTORS];
  logic signed [CUR_W-1:0] o_cur [NUM_MOTORS];
  out_t                    result_q;

  // ---------------- stage 2: current, speed and their products ----------------
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      s2_x_d[i][0] = 32'(s1_cur_q[i]);
      s2_x_d[i][1] = 32'(s1_spd_q[i]);
      s2_x_d[i][2] = 32'(s1_cur_q[i]) * 32'(s1_spd_q[i]);
      s2_x_d[i][3] = 32'(s1_cur_q[i]) * 32'(s1_cur_q[i]);
      s2_x_d[i][4] = 32'(s1_spd_q[i]) * 32'(s1_spd_q[i]);
    end
  end

  // ---------------- stage 3: coefficient split in halves ----------------
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      for (int j = 0; j < NK; j++) begin
        s3_ph_d[i][j] = 56'($signed(coef_q[j+1][47:24])) * 56'(s2_x_q[i][j]);
        s3_pl_d[i][j] = 57'($signed({1'b0, coef_q[j+1][23:0]})) * 57'(s2_x_q[i][j]);
      end
    end
  end

  // ---------------- stage 4: floor of product over 2^32 ----------------
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      for (int j = 0; j < NK; j++) begin
        s4_full[i][j] = (81'(s3_ph_q[i][j]) <<< 24) + 81'(s3_pl_q[i][j]);
      end
    end
  end

  // ---------------- stage 6: A, B and C totals ----------------
  always_comb begin
    s6_a_d = '0;
    s6_b_d = '0;
    s6_c_d = SW'($signed(coef_q[0][47:32])) <<< 2;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      s6_a_d = s6_a_d + SW'(s5_a_q[i]);
      s6_b_d = s6_b_d + SW'(s5_b_q[i]);
      s6_c_d = s6_c_d + SW'(s5_c_q[i]);
    end
  end

  // ---------------- stage 7: limit check and C less the limit ----------------
  assign s7_lim   = $signed({32'd0, s6_lim_q});
  assign s7_total = s6_a_q + s6_b_q + s6_c_q;

  // ---------------- stage 9: normalising shift ----------------
  always_comb begin
    s9_or   = s8_mag_q[0] | s8_mag_q[1] | s8_mag_q[2];
    s9_sh_d = '0;
    for (int p = 30; p < SW; p++) begin
      if (s9_or[p]) s9_sh_d = 5'(p - 29);
    end
  end

  // ---------------- stage 10: shrink and linear case flags ----------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s10_shr[k] = s9_mag_q[k] >> s9_sh_q;
      s10_v[k]   = s9_sgn_q[k] ? -$signed({1'b0, s10_shr[k][29:0]})
                               : $signed({1'b0, s10_shr[k][29:0]});
    end
    s10_side_d.limited = s9_limited_q;
    s10_side_d.a_zero  = (s10_shr[0][29:0] == '0);
    s10_side_d.d_neg   = 1'b0;
    s10_side_d.lin_ok  = (s9_mag_q[1] != '0) && (s9_mag_q[2] != '0) &&
                         (s9_sgn_q[1] != s9_sgn_q[2]) && (s9_mag_q[2] <= s9_mag_q[1]);
    s10_side_d.a2      = s10_v[0];
    s10_side_d.b2      = s10_v[1];
    s10_side_d.mag_b   = s9_mag_q[1];
    s10_side_d.mag_c   = s9_mag_q[2];
    for (int i = 0; i < NUM_MOTORS; i++) s10_side_d.cur[i] = s9_cur_q[i];
  end

  // ---------------- stage 12 and square root steps ----------------
  assign s12_delta = 64'(s11_bb_q) - (64'(s11_ac_q) <<< 2);

  always_comb begin
    sq_v_d[0]          = s12_delta[63] ? '0 : s12_delta[62:0];
    sq_r_d[0]          = '0;
    sq_side_d[0]       = s11_side_q;
    sq_side_d[0].d_neg = s12_delta[63];
    for (int k = 0; k < SQ_N; k++) begin
      sq_bit[k] = 63'(1) << (62 - 2 * k);
      sq_sum[k] = {1'b0, sq_r_q[k]} + {1'b0, sq_bit[k]};
      if ({1'b0, sq_v_q[k]} >= sq_sum[k]) begin
        sq_v_d[k+1] = sq_v_q[k] - sq_sum[k][62:0];
        sq_r_d[k+1] = (sq_r_q[k] >> 1) + sq_bit[k];
      end else begin
        sq_v_d[k+1] = sq_v_q[k];
        sq_r_d[k+1] = sq_r_q[k] >> 1;
      end
      sq_side_d[k+1] = sq_side_q[k];
    end
  end

  // ---------------- root numerators, positive denominator ----------------
  always_comb begin
    r1_sq = $signed({2'b00, sq_r_q[SQ_N][31:0]});
    r1_nb = -34'(sq_side_q[SQ_N].b2);
    r1_d_d    = 33'(sq_side_q[SQ_N].a2) <<< 1;
    r1_n_d[0] = r1_nb + r1_sq;
    r1_n_d[1] = r1_nb - r1_sq;
    if (r1_d_d[32]) begin
      r1_d_d    = -r1_d_d;
      r1_n_d[0] = -r1_n_d[0];
      r1_n_d[1] = -r1_n_d[1];
    end
  end

  // ---------------- lane set-up and divider steps ----------------
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r2_inv[l] = r1_n_q[l][33] || (46'(r1_n_q[l]) * K1000 > 46'(r1_d_q) * K1001);
      r2_one[l] = r1_n_q[l] >= 34'(r1_d_q);
      if (r2_inv[l])      r2_root_mode[l] = LANE_ZERO;
      else if (r2_one[l]) r2_root_mode[l] = LANE_ONE;
      else                r2_root_mode[l] = LANE_DIV;
      dv_rem_d[0][l] = {20'd0, r1_n_q[l]};
      dv_den_d[0][l] = {21'd0, r1_d_q};
      dv_quo_d[0][l] = '0;
    end
    // Lane 0 carries the linear solution when A vanished
    if (r1_side_q.a_zero) begin
      dv_mode_d[0][0] = r1_side_q.lin_ok ? LANE_DIV : LANE_ZERO;
      dv_mode_d[0][1] = LANE_ZERO;
      dv_rem_d[0][0]  = {2'b00, r1_side_q.mag_c};
      dv_den_d[0][0]  = {2'b00, r1_side_q.mag_b};
    end else if (r1_side_q.d_neg) begin
      dv_mode_d[0][0] = LANE_ZERO;
      dv_mode_d[0][1] = LANE_ZERO;
    end else begin
      dv_mode_d[0][0] = r2_root_mode[0];
      dv_mode_d[0][1] = r2_root_mode[1];
    end
    dv_lim_d[0] = r1_side_q.limited;
    dv_cur_d[0] = r1_side_q.cur;

    // Restoring division, one quotient bit per stage
    for (int k = 0; k < DV_N; k++) begin
      for (int l = 0; l < 2; l++) begin
        dv_rr[k][l] = (k == 0) ? dv_rem_q[k][l] : {dv_rem_q[k][l][RW-2:0], 1'b0};
        if (dv_rr[k][l] >= dv_den_q[k][l]) begin
          dv_rem_d[k+1][l] = dv_rr[k][l] - dv_den_q[k][l];
          dv_quo_d[k+1][l] = {dv_quo_q[k][l][ETA_W-2:0], 1'b1};
        end else begin
          dv_rem_d[k+1][l] = dv_rr[k][l];
          dv_quo_d[k+1][l] = {dv_quo_q[k][l][ETA_W-2:0], 1'b0};
        end
        dv_den_d[k+1][l]  = dv_den_q[k][l];
        dv_mode_d[k+1][l] = dv_mode_q[k][l];
      end
      dv_lim_d[k+1] = dv_lim_q[k];
      dv_cur_d[k+1] = dv_cur_q[k];
    end
  end

  // ---------------- larger root wins ----------------
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      unique case (dv_mode_q[DV_N][l])
        LANE_ONE: e_lane[l] = ETA_ONE;
        LANE_DIV: e_lane[l] = dv_quo_q[DV_N][l];
        default:  e_lane[l] = '0;
      endcase
    end
    e_eta_d = (e_lane[0] > e_lane[1]) ? e_lane[0] : e_lane[1];
    if (!dv_lim_q[DV_N]) e_eta_d = ETA_ONE;
  end

  // ---------------- output: truncate toward zero ----------------
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      o_mag[i] = m_p_q[i][32] ? 33'(-m_p_q[i]) : 33'(m_p_q[i]);
      o_shr[i] = o_mag[i][32:15];
      o_cur[i] = m_p_q[i][32] ? -$signed(o_shr[i][15:0]) : $signed(o_shr[i][15:0]);
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    // stage 1: capture beat
    s1_cur_q[0] <= in_i.current_0;
    s1_cur_q[1] <= in_i.current_1;
    s1_cur_q[2] <= in_i.current_2;
    s1_cur_q[3] <= in_i.current_3;
    s1_spd_q[0] <= in_i.speed_0;
    s1_spd_q[1] <= in_i.speed_1;
    s1_spd_q[2] <= in_i.speed_2;
    s1_spd_q[3] <= in_i.speed_3;
    s1_lim_q    <= in_i.power_limit;

    s2_x_q   <= s2_x_d;
    s2_cur_q <= s1_cur_q;
    s2_lim_q <= s1_lim_q;

    s3_ph_q  <= s3_ph_d;
    s3_pl_q  <= s3_pl_d;
    s3_cur_q <= s2_cur_q;
    s3_lim_q <= s2_lim_q;

    for (int i = 0; i < NUM_MOTORS; i++) begin
      for (int j = 0; j < NK; j++) s4_t_q[i][j] <= s4_full[i][j][79:32];
    end
    s4_cur_q <= s3_cur_q;
    s4_lim_q <= s3_lim_q;

    // stage 5: per motor A, B, C parts
    for (int i = 0; i < NUM_MOTORS; i++) begin
      s5_a_q[i] <= 49'(s4_t_q[i][3]);
      s5_b_q[i] <= 49'(s4_t_q[i][0]) + 49'(s4_t_q[i][2]);
      s5_c_q[i] <= 49'(s4_t_q[i][1]) + 49'(s4_t_q[i][4]);
    end
    s5_cur_q <= s4_cur_q;
    s5_lim_q <= s4_lim_q;

    s6_a_q   <= s6_a_d;
    s6_b_q   <= s6_b_d;
    s6_c_q   <= s6_c_d;
    s6_cur_q <= s5_cur_q;
    s6_lim_q <= s5_lim_q;

    s7_a_q       <= s6_a_q;
    s7_b_q       <= s6_b_q;
    s7_c_q       <= s6_c_q - s7_lim;
    s7_limited_q <= s7_total > s7_lim;
    s7_cur_q     <= s6_cur_q;

    // stage 8: magnitudes and signs
    s8_mag_q[0]  <= mag_f(s7_a_q);
    s8_mag_q[1]  <= mag_f(s7_b_q);
    s8_mag_q[2]  <= mag_f(s7_c_q);
    s8_sgn_q     <= {s7_c_q[SW-1], s7_b_q[SW-1], s7_a_q[SW-1]};
    s8_limited_q <= s7_limited_q;
    s8_cur_q     <= s7_cur_q;

    s9_sh_q      <= s9_sh_d;
    s9_mag_q     <= s8_mag_q;
    s9_sgn_q     <= s8_sgn_q;
    s9_limited_q <= s8_limited_q;
    s9_cur_q     <= s8_cur_q;

    s10_c2_q   <= s10_v[2];
    s10_side_q <= s10_side_d;

    // stage 11: discriminant products
    s11_bb_q   <= 62'(s10_side_q.b2) * 62'(s10_side_q.b2);
    s11_ac_q   <= 62'(s10_side_q.a2) * 62'(s10_c2_q);
    s11_side_q <= s10_side_q;

    sq_v_q    <= sq_v_d;
    sq_r_q    <= sq_r_d;
    sq_side_q <= sq_side_d;

    r1_n_q    <= r1_n_d;
    r1_d_q    <= r1_d_d;
    r1_side_q <= sq_side_q[SQ_N];

    dv_rem_q  <= dv_rem_d;
    dv_den_q  <= dv_den_d;
    dv_quo_q  <= dv_quo_d;
    dv_mode_q <= dv_mode_d;
    dv_lim_q  <= dv_lim_d;
    dv_cur_q  <= dv_cur_d;

    e_eta_q <= e_eta_d;
    e_lim_q <= dv_lim_q[DV_N];
    e_cur_q <= dv_cur_q[DV_N];

    // scale currents by eta
    for (int i = 0; i < NUM_MOTORS; i++) begin
      m_p_q[i] <= 33'($signed(e_cur_q[i])) * $signed({17'd0, e_eta_q});
    end
    m_eta_q <= e_eta_q;
    m_lim_q <= e_lim_q;

    result_q.out_current_0 <= o_cur[0];
    result_q.out_current_1 <= o_cur[1];
    result_q.out_current_2 <= o_cur[2];
    result_q.out_current_3 <= o_cur[3];
    result_q.scale_factor  <= m_eta_q;
    result_q.was_limited   <= m_lim_q;
  end

  assign result_valid_o = vld_q[LATENCY-1];
  assign result_o       = result_q;

endmodule

// ===== src/mpls_checker.sv =====
module mpls_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  mpls_pkg::in_t                  in_i,
  input  logic                           result_valid_o,
  input  mpls_pkg::out_t                 result_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o
);
  import mpls_pkg::*;

  // every result beat goes back to a command beat a fixed latency earlier
  a_result_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result beat without matching command");

  // within the cap the currents pass unchanged at full scale
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.was_limited |->
      result_o.scale_factor == ETA_ONE &&
      result_o.out_current_0 == $past(in_i.current_0, LATENCY) &&
      result_o.out_current_1 == $past(in_i.current_1, LATENCY) &&
      result_o.out_current_2 == $past(in_i.current_2, LATENCY) &&
      result_o.out_current_3 == $past(in_i.current_3, LATENCY))
    else $error("unlimited beat altered currents");

  // eta never exceeds one
  a_eta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.scale_factor <= ETA_ONE)
    else $error("scale factor above one");

  // zero eta zeroes every current
  a_zero_eta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.scale_factor == '0 |->
      result_o.out_current_0 == '0 && result_o.out_current_1 == '0 &&
      result_o.out_current_2 == '0 && result_o.out_current_3 == '0)
    else $error("zero scale with non-zero current");

  // a coefficient write is never held off
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("coefficient write held off");

endmodule

bind motor_power_limit_scaler mpls_checker u_mpls_checker (.*);
